/* rtl/core/ssc_pkg.sv */
// Shared types and constants for the sorted key set with cursor.
// Holds command, status and cell-control encodings used by the cell row and top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ssc_pkg;

	localparam int DEF_CAPACITY = 16;
	localparam int DEF_KEY_BITS = 32;

	// fixed field widths on the stream ports
	localparam int KEY_W    = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CONTAINS = 3'd0,
		CMD_ADD      = 3'd1,
		CMD_REMOVE   = 3'd2,
		CMD_GET      = 3'd3,
		CMD_NEXT     = 3'd4,
		CMD_PREV     = 3'd5,
		CMD_FIRST    = 3'd6,
		CMD_LAST     = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_CONTAINS     = 3'd1,
		ST_NOT_CONTAINS = 3'd2,
		ST_EMPTY        = 3'd3,
		ST_OUT_OF_BOUND = 3'd4,
		ST_FULL         = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INS,
		OP_REM,
		OP_NEXT,
		OP_PREV,
		OP_FIRST,
		OP_LAST
	} cell_op_t;

	// broadcast to every cell
	typedef struct packed {
		cell_op_t op;
		logic     empty;
	} cell_ctl_t;

	// flags one cell hands to its neighbours
	typedef struct packed {
		logic lt;     // holds a valid key below the search key
		logic cur;    // cursor marker
		logic valid;  // slot occupied
	} cell_link_t;

endpackage

`default_nettype wire

/* rtl/core/ssc_cell.sv */
// One slot of the sorted key row: key register, cursor marker and shift logic.
// Exchanges key and flags with both neighbours every cycle.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_cell #(
	parameter int KW    = 32,
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ssc_pkg::cell_ctl_t      ctl,
	input  wire  [KW-1:0]           key_in,
	input  wire  [CNT_W-1:0]        count,
	input  wire  [KW-1:0]           left_key,
	input  ssc_pkg::cell_link_t     left,
	input  wire  [KW-1:0]           right_key,
	input  ssc_pkg::cell_link_t     right,
	output logic [KW-1:0]           key_o,
	output ssc_pkg::cell_link_t     link,
	output logic                    hit,
	output logic                    cur_last
);
	import ssc_pkg::*;

	localparam logic FIRST_CELL = (IDX == 0);

	logic [KW-1:0] key_q, key_d;
	logic          cur_q, cur_d;
	logic          valid, lt, at_pos;

	assign valid  = (CNT_W'(IDX) < count);
	assign lt     = valid && (key_q < key_in);
	assign hit    = valid && (key_q == key_in);
	assign at_pos = left.lt && !lt;

	assign key_o    = key_q;
	assign link     = '{lt: lt, cur: cur_q, valid: valid};
	assign cur_last = cur_q && valid && !right.valid;

	always_comb begin
		key_d = key_q;
		cur_d = cur_q;
		unique case (ctl.op)
			OP_INS: begin
				if (!lt) begin
					key_d = at_pos ? key_in : left_key;
					cur_d = at_pos ? 1'b0 : left.cur;
				end
				if (ctl.empty)
					cur_d = at_pos;
			end
			OP_REM: begin
				if (lt) begin
					// cursor on the removed key falls back to this slot
					cur_d = cur_q || (!right.lt && right.cur);
				end else begin
					key_d = right_key;
					cur_d = right.cur || (at_pos && FIRST_CELL && cur_q);
				end
			end
			OP_NEXT:  cur_d = left.cur;
			OP_PREV:  cur_d = right.cur;
			OP_FIRST: cur_d = FIRST_CELL;
			OP_LAST:  cur_d = valid && !right.valid;
			default: begin
				key_d = key_q;
				cur_d = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= FIRST_CELL;
		end else begin
			cur_q <= cur_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sorted_set_with_cursor.sv */
// Top level of the sorted key set with browsing cursor.
// Decodes commands, drives the row of ssc_cell slots and registers the result.
// Depends on ssc_pkg and ssc_cell.
//
//  channel | dir | tdata                        | tuser
//  --------+-----+------------------------------+--------------
//  s_*     | in  | key                          | cmd
//  m_*     | out | cursor_key, count (zero pad) | status
//
// One command per cycle while s_tready is high; each result passes through valid_s1 and
// then the output register before m_tvalid rises and the result can be taken.
// Search, insert and remove all happen in the cell row in the accept cycle,
// every slot comparing its own key; the cursor-key pick reads the updated row.
// Reset clears the count and puts the cursor on slot 0; no clearing pass.
// A stalled result holds s_tready low once the result stage is also full.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_with_cursor #(
	parameter int CAPACITY = ssc_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = ssc_pkg::DEF_KEY_BITS,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int OUT_W    = ssc_pkg::KEY_W + CNT_W,
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [ssc_pkg::KEY_W-1:0]        s_tdata,   // [31:0] key
	input  wire  [ssc_pkg::CMD_W-1:0]        s_tuser,   // [2:0] cmd
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [OUT_TD_W-1:0]              m_tdata,   // cursor_key, count, zero pad
	output logic [ssc_pkg::STATUS_W-1:0]     m_tuser    // [2:0] status
);
	import ssc_pkg::*;

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

	logic [KW-1:0]    key_in;
	cmd_t             cmd;
	logic             accept, out_free;
	logic [CNT_W-1:0] count_q, count_d;
	logic             empty, full, found, at_last, at_first;
	status_t          status_d;
	cell_op_t         op_d;
	cell_ctl_t        ctl;

	logic [KW-1:0]    cell_key  [CAPACITY];
	cell_link_t       cell_link [CAPACITY];
	logic [CAPACITY-1:0] hit_v, last_v;

	logic             valid_s1;
	status_t          status_s1;
	logic             out_valid_q;
	status_t          out_status_q;
	logic [KW-1:0]    out_key_q;
	logic [CNT_W-1:0] out_count_q;
	logic [KW-1:0]    cur_key;

	assign key_in   = s_tdata[KW-1:0];
	assign cmd      = cmd_t'(s_tuser);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign found    = |hit_v;
	assign at_last  = |last_v;
	assign at_first = cell_link[0].cur;

	always_comb begin
		status_d = ST_OK;
		op_d     = OP_NONE;
		count_d  = count_q;
		if (empty && cmd != CMD_ADD) begin
			status_d = ST_EMPTY;
		end else begin
			unique case (cmd)
				CMD_CONTAINS: status_d = found ? ST_CONTAINS : ST_NOT_CONTAINS;
				CMD_ADD: begin
					if (found) begin
						status_d = ST_CONTAINS;
					end else if (full) begin
						status_d = ST_FULL;
					end else begin
						op_d    = OP_INS;
						count_d = count_q + CNT_W'(1);
					end
				end
				CMD_REMOVE: begin
					if (!found) begin
						status_d = ST_NOT_CONTAINS;
					end else begin
						op_d    = OP_REM;
						count_d = count_q - CNT_W'(1);
					end
				end
				CMD_GET: status_d = ST_OK;
				CMD_NEXT: begin
					if (at_last) status_d = ST_OUT_OF_BOUND;
					else         op_d     = OP_NEXT;
				end
				CMD_PREV: begin
					if (at_first) status_d = ST_OUT_OF_BOUND;
					else          op_d     = OP_PREV;
				end
				CMD_FIRST: op_d = OP_FIRST;
				CMD_LAST:  op_d = OP_LAST;
				default:   status_d = ST_OK;
			endcase
		end
	end

	assign ctl = '{op: accept ? op_d : OP_NONE, empty: empty};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0] lkey, rkey;
		cell_link_t    llink, rlink;

		if (i == 0) begin : g_lend
			assign lkey  = '0;
			assign llink = '{lt: 1'b1, cur: 1'b0, valid: 1'b1};
		end else begin : g_lnbr
			assign lkey  = cell_key[i-1];
			assign llink = cell_link[i-1];
		end

		if (i == CAPACITY - 1) begin : g_rend
			assign rkey  = '0;
			assign rlink = '{lt: 1'b0, cur: 1'b0, valid: 1'b0};
		end else begin : g_rnbr
			assign rkey  = cell_key[i+1];
			assign rlink = cell_link[i+1];
		end

		ssc_cell #(
			.KW    (KW),
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key_in    (key_in),
			.count     (count_q),
			.left_key  (lkey),
			.left      (llink),
			.right_key (rkey),
			.right     (rlink),
			.key_o     (cell_key[i]),
			.link      (cell_link[i]),
			.hit       (hit_v[i]),
			.cur_last  (last_v[i])
		);
	end

	// cursor marker is one-hot, so an and-or picks its key
	always_comb begin
		cur_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			cur_key = cur_key | (cell_key[i] & {KW{cell_link[i].cur}});
		end
		if (empty)
			cur_key = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)
				count_q <= count_d;
			if (accept)
				valid_s1 <= 1'b1;
			else if (out_free)
				valid_s1 <= 1'b0;
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			status_s1 <= status_d;
		if (out_free && valid_s1) begin
			out_status_q <= status_s1;
			out_key_q    <= cur_key;
			out_count_q  <= count_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = OUT_TD_W'({out_count_q, KEY_W'(out_key_q)});

endmodule

`default_nettype wire

/* rtl/core/ssc_checker.sv */
// Port-level checks for sorted_set_with_cursor, bound to every instance.
// Depends on ssc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssc_checker #(
	parameter int CAPACITY = ssc_pkg::DEF_CAPACITY,
	parameter int KEY_BITS = ssc_pkg::DEF_KEY_BITS,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int OUT_W    = ssc_pkg::KEY_W + CNT_W,
	localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_tvalid,
	input wire                          s_tready,
	input wire [ssc_pkg::KEY_W-1:0]     s_tdata,
	input wire [ssc_pkg::CMD_W-1:0]     s_tuser,
	input wire                          m_tvalid,
	input wire                          m_tready,
	input wire [OUT_TD_W-1:0]           m_tdata,
	input wire [ssc_pkg::STATUS_W-1:0]  m_tuser
);
	import ssc_pkg::*;

	logic [KEY_W-1:0] res_key;
	logic [CNT_W-1:0] res_count;
	logic             in_xfer;

	assign res_key   = m_tdata[KEY_W-1:0];
	assign res_count = m_tdata[KEY_W +: CNT_W];
	assign in_xfer   = s_tvalid && s_tready && (s_tuser != '1 || s_tdata != '0 || 1'b1);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_count <= CNT_W'(CAPACITY))
		else $error("result count above capacity");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_count == '0 |->
			res_key == '0 && (m_tuser == ST_EMPTY || m_tuser == ST_OK))
		else $error("empty set with bad cursor key or status");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> res_count == CNT_W'(CAPACITY))
		else $error("full reported below capacity");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing two cycles after transaction");

endmodule

bind sorted_set_with_cursor ssc_checker #(
	.CAPACITY (CAPACITY),
	.KEY_BITS (KEY_BITS)
) u_ssc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* bench/tb_sorted_set_with_cursor.sv */
// Self-checking bench for sorted_set_with_cursor: a directed command table, then
// random phases, each result checked against the table or an in-bench model of the set.
// Depends on ssc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_set_with_cursor;
	import ssc_pkg::*;

	localparam int CAP      = DEF_CAPACITY;
	localparam int CNT_W    = $clog2(CAP + 1);
	localparam int OUT_TD_W = ((KEY_W + CNT_W + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 1850;
	localparam int PHASE_ITEMS  = 150;
	localparam int LONG_HOLD    = 80;
	localparam int POOL_N       = 24;
	localparam int CYCLE_LIMIT  = 600000;

	typedef struct {
		status_t          status;
		logic [KEY_W-1:0] cursor_key;
		logic [CNT_W-1:0] count;
	} reply_t;

	typedef struct {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		bit               typed;
		reply_t           want;
	} script_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [KEY_W-1:0]    s_tdata  = '0;
	logic [CMD_W-1:0]    s_tuser  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_TD_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;

	// model of the set
	logic [KEY_W-1:0] set_keys [CAP];
	int               set_count;
	int               set_cursor;

	reply_t      pending_replies [$];
	script_row_t script [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int  mismatches    = 0;
	int  cycle_no      = 0;
	int  hold_requests = 0;
	int  holds_done    = 0;
	int  rx_hold_left  = 0;
	int  rx_stall_left = 0;
	bit  tx_calm       = 1'b0;
	bit  rx_calm       = 1'b0;

	sorted_set_with_cursor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_no++;
		if (cycle_no >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_no);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// apply one command to the set model and return the result it gives
	task automatic apply_command(input cmd_t c, input logic [KEY_W-1:0] k, output reply_t r);
		int      pos;
		int      i;
		bit      found;
		status_t st;
		st = ST_OK;
		if (set_count == 0 && c != CMD_ADD) begin
			st = ST_EMPTY;
		end else begin
			pos = 0;
			while (pos < set_count && set_keys[pos] < k)
				pos++;
			found = (pos < set_count) && (set_keys[pos] == k);
			case (c)
				CMD_CONTAINS: st = found ? ST_CONTAINS : ST_NOT_CONTAINS;
				CMD_ADD: begin
					if (found) begin
						st = ST_CONTAINS;
					end else if (set_count >= CAP) begin
						st = ST_FULL;
					end else begin
						for (i = set_count; i > pos; i--)
							set_keys[i] = set_keys[i-1];
						set_keys[pos] = k;
						if (set_count == 0)
							set_cursor = 0;
						else if (pos <= set_cursor)
							set_cursor++;
						set_count++;
					end
				end
				CMD_REMOVE: begin
					if (!found) begin
						st = ST_NOT_CONTAINS;
					end else begin
						for (i = pos; i < set_count - 1; i++)
							set_keys[i] = set_keys[i+1];
						set_count--;
						// cursor key gone: step back, or forward when at the front
						if (set_cursor > pos)
							set_cursor--;
						else if (set_cursor == pos && pos > 0)
							set_cursor = pos - 1;
						if (set_count == 0)
							set_cursor = 0;
					end
				end
				CMD_GET: st = ST_OK;
				CMD_NEXT: begin
					if (set_cursor + 1 >= set_count)
						st = ST_OUT_OF_BOUND;
					else
						set_cursor++;
				end
				CMD_PREV: begin
					if (set_cursor == 0)
						st = ST_OUT_OF_BOUND;
					else
						set_cursor--;
				end
				CMD_FIRST: set_cursor = 0;
				default: set_cursor = set_count - 1;
			endcase
		end
		if (set_count != 0 && set_cursor >= set_count)
			set_cursor = set_count - 1;
		r.status     = st;
		r.cursor_key = (set_count != 0) ? set_keys[set_cursor] : '0;
		r.count      = CNT_W'(set_count);
	endtask

	// offer one command; record its expected result once the transaction completes
	task automatic put_command(input cmd_t c, input logic [KEY_W-1:0] k, input bit typed,
			input reply_t want);
		int     gap;
		reply_t pred;
		gap = tx_calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= k;
		s_tuser  <= c;
		do
			@(posedge clk);
		while (!s_tready);
		apply_command(c, k, pred);
		pending_replies.push_back(typed ? want : pred);
	endtask

	task automatic add_row(input cmd_t c, input logic [KEY_W-1:0] k, input bit typed,
			input status_t st, input logic [KEY_W-1:0] ck, input int n);
		script_row_t row;
		row.cmd             = c;
		row.key             = k;
		row.typed           = typed;
		row.want.status     = st;
		row.want.cursor_key = ck;
		row.want.count      = CNT_W'(n);
		script.push_back(row);
	endtask

	function automatic cmd_t pick_cmd(input int phase);
		int r;
		int add_pct;
		int rem_pct;
		int has_pct;
		case (phase)
			0: begin add_pct = 55; rem_pct = 8;  has_pct = 10; end
			1: begin add_pct = 25; rem_pct = 20; has_pct = 15; end
			2: begin add_pct = 12; rem_pct = 55; has_pct = 10; end
			default: begin add_pct = 12; rem_pct = 8; has_pct = 10; end
		endcase
		r = $urandom_range(0, 99);
		if (r < add_pct)
			return CMD_ADD;
		if (r < add_pct + rem_pct)
			return CMD_REMOVE;
		if (r < add_pct + rem_pct + has_pct)
			return CMD_CONTAINS;
		return cmd_t'(CMD_W'($urandom_range(CMD_GET, CMD_LAST)));
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return $urandom;
	endfunction

	// pool larger than the table, so full is reached and present keys recur
	task automatic refill_pool();
		int i;
		for (i = 0; i < POOL_N; i++) begin
			case ($urandom_range(0, 3))
				0: key_pool[i] = $urandom;
				1: key_pool[i] = KEY_W'($urandom_range(0, 40));
				2: key_pool[i] = 32'hFFFF_FFFF - KEY_W'($urandom_range(0, 40));
				default: key_pool[i] = 32'h8000_0000 + KEY_W'($urandom_range(0, 15));
			endcase
		end
	endtask

	// receiver: random stalls, calm stretches and the occasional long hold-off
	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				rx_hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				m_tready <= 1'b0;
				rx_stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		reply_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status     = status_t'(m_tuser);
			got.cursor_key = m_tdata[KEY_W-1:0];
			got.count      = m_tdata[KEY_W +: CNT_W];
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result status %0d cursor_key %h count %0d",
					$time, got.status, got.cursor_key, got.count);
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						got.status);
					mismatches++;
				end
				if (got.cursor_key !== want.cursor_key) begin
					$display("%0t: cursor_key expected %h got %h", $time, want.cursor_key,
						got.cursor_key);
					mismatches++;
				end
				if (got.count !== want.count) begin
					$display("%0t: count expected %0d got %0d", $time, want.count,
						got.count);
					mismatches++;
				end
			end
		end
	end

	initial begin
		reply_t none;
		int     sent;
		int     phase_no;
		int     n;
		none = '{ST_OK, '0, '0};
		set_count  = 0;
		set_cursor = 0;

		// empty set first, then a three-key set walked to both ends
		add_row(CMD_CONTAINS, 32'h0000_0000, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_REMOVE,   32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_GET,      32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_NEXT,     32'h0000_0000, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_PREV,     32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_FIRST,    32'h0000_0000, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_LAST,     32'hFFFF_FFFF, 1, ST_EMPTY, 32'h0, 0);
		add_row(CMD_ADD,      32'h8000_0000, 1, ST_OK, 32'h8000_0000, 1);
		add_row(CMD_ADD,      32'h0000_0000, 1, ST_OK, 32'h8000_0000, 2);
		add_row(CMD_ADD,      32'hFFFF_FFFF, 1, ST_OK, 32'h8000_0000, 3);
		add_row(CMD_ADD,      32'h0000_0000, 1, ST_CONTAINS, 32'h8000_0000, 3);
		add_row(CMD_CONTAINS, 32'hFFFF_FFFF, 1, ST_CONTAINS, 32'h8000_0000, 3);
		add_row(CMD_CONTAINS, 32'h1234_5678, 1, ST_NOT_CONTAINS, 32'h8000_0000, 3);
		add_row(CMD_LAST,     32'h0000_0000, 1, ST_OK, 32'hFFFF_FFFF, 3);
		add_row(CMD_NEXT,     32'h0000_0000, 1, ST_OUT_OF_BOUND, 32'hFFFF_FFFF, 3);
		add_row(CMD_FIRST,    32'hFFFF_FFFF, 1, ST_OK, 32'h0000_0000, 3);
		add_row(CMD_PREV,     32'hFFFF_FFFF, 1, ST_OUT_OF_BOUND, 32'h0000_0000, 3);
		add_row(CMD_NEXT,     32'h5555_5555, 0, ST_OK, 32'h0, 0);
		add_row(CMD_REMOVE,   32'h8000_0000, 0, ST_OK, 32'h0, 0);
		add_row(CMD_REMOVE,   32'h0000_0007, 1, ST_NOT_CONTAINS, 32'h0000_0000, 2);
		add_row(CMD_REMOVE,   32'h0000_0000, 0, ST_OK, 32'h0, 0);
		add_row(CMD_GET,      32'hAAAA_AAAA, 0, ST_OK, 32'h0, 0);
		add_row(CMD_REMOVE,   32'hFFFF_FFFF, 1, ST_OK, 32'h0000_0000, 0);
		add_row(CMD_ADD,      32'h5A5A_5A5A, 0, ST_OK, 32'h0, 0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			put_command(script[i].cmd, script[i].key, script[i].typed, script[i].want);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending_replies.size() == 0);

		sent     = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_no % 4 == 0)
				refill_pool();
			tx_calm = ($urandom_range(0, 4) == 0);
			rx_calm = ($urandom_range(0, 4) == 0);
			// long receiver hold-off while the sender keeps offering back to back
			if (phase_no % 5 == 1) begin
				tx_calm = 1'b1;
				hold_requests++;
			end
			for (n = 0; n < PHASE_ITEMS && sent < RANDOM_ITEMS; n++) begin
				put_command(pick_cmd(phase_no % 4), pick_key(), 0, none);
				sent++;
			end
			// sender pause until the block has returned everything
			if (phase_no % 3 == 2 || $urandom_range(0, 3) == 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				wait (pending_replies.size() == 0);
			end
			phase_no++;
		end
		@(negedge clk);
		s_tvalid <= 1'b0;
		rx_calm = 1'b1;

		wait (pending_replies.size() == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/ssc_pkg.sv
rtl/core/ssc_cell.sv
rtl/core/sorted_set_with_cursor.sv
rtl/core/ssc_checker.sv
bench/tb_sorted_set_with_cursor.sv
